>>> hdl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned TimeWidth = 32;

  localparam logic [CfgWidth-1:0] DebounceMsRst = 16'd15;
  localparam logic [CfgWidth-1:0] ShortMaxMsRst = 16'd1000;
  localparam logic [CfgWidth-1:0] LongMinMsRst  = 16'd3000;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE_MS  = 2'd0,
    CFG_SHORT_MAX_MS = 2'd1,
    CFG_LONG_MIN_MS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ms;
    logic [CfgWidth-1:0] short_max_ms;
    logic [CfgWidth-1:0] long_min_ms;
  } cfg_t;

  typedef struct packed {
    logic                 raw_level;
    logic [TimeWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
    logic short_press_event;
    logic long_press_event;
    logic stable_level;
  } result_t;

endpackage

>>> hdl/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces an active-low button poll stream and flags press, release,
// short press and long press events, one result item per poll item.
// ----------------------------------------------------------------------------
// path: a poll item passes through the input register and then the result
// register; a stalled output holds it in the input register in between
// throughput: one item per cycle unless the output stalls, set by the
// state update between the input register and the result register
// reset: asynchronous, active low; configuration returns to 15/1000/3000 ms,
// button state returns to released, both stages empty
module button_debounce_press_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [bdpc_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           raw_level_i,
  input  logic [bdpc_pkg::TimeWidth-1:0] now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           press_event_o,
  output logic                           release_event_o,
  output logic                           short_press_event_o,
  output logic                           long_press_event_o,
  output logic                           stable_level_o
);

  bdpc_pkg::cfg_t     cfg;
  bdpc_pkg::in_item_t in_item, stage_item;
  bdpc_pkg::result_t  result;
  logic               stage_valid, stage_take;

  assign in_item.raw_level = raw_level_i;
  assign in_item.now_ms    = now_ms_i;

  bdpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdpc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .item_valid_o (stage_valid),
    .item_take_i  (stage_take),
    .item_o       (stage_item)
  );

  bdpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (stage_valid),
    .item_take_o  (stage_take),
    .item_i       (stage_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign press_event_o       = result.press_event;
  assign release_event_o     = result.release_event;
  assign short_press_event_o = result.short_press_event;
  assign long_press_event_o  = result.long_press_event;
  assign stable_level_o      = result.stable_level;

endmodule

>>> hdl/bdpc_cfg.sv
// ----------------------------------------------------------------------------
// bdpc_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bdpc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [bdpc_pkg::CfgWidth-1:0] cfg_wdata_i,
  output bdpc_pkg::cfg_t                cfg_o
);

  bdpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bdpc_pkg::cfg_idx_e'(cfg_idx_i))
        bdpc_pkg::CFG_DEBOUNCE_MS:  cfg_d.debounce_ms  = cfg_wdata_i;
        bdpc_pkg::CFG_SHORT_MAX_MS: cfg_d.short_max_ms = cfg_wdata_i;
        bdpc_pkg::CFG_LONG_MIN_MS:  cfg_d.long_min_ms  = cfg_wdata_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= bdpc_pkg::DebounceMsRst;
      cfg_q.short_max_ms <= bdpc_pkg::ShortMaxMsRst;
      cfg_q.long_min_ms  <= bdpc_pkg::LongMinMsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/bdpc_in_stage.sv
// ----------------------------------------------------------------------------
// bdpc_in_stage
// Input register that holds one poll item until the core takes it.
// ----------------------------------------------------------------------------
module bdpc_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bdpc_pkg::in_item_t   item_i,
  output logic                 item_valid_o,
  input  logic                 item_take_i,
  output bdpc_pkg::in_item_t   item_o
);

  logic               valid_q, valid_d;
  bdpc_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> hdl/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core
// Debounce and press state, event logic and result register.
// ----------------------------------------------------------------------------
module bdpc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bdpc_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  bdpc_pkg::in_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bdpc_pkg::result_t  result_o
);

  localparam int unsigned TW = bdpc_pkg::TimeWidth;
  localparam int unsigned CW = bdpc_pkg::CfgWidth;

  logic          filter_q, filter_d;
  logic          deb_q, deb_d;
  logic          debouncing_q, debouncing_d;
  logic [TW-1:0] deb_start_q, deb_start_d;
  logic          long_pend_q, long_pend_d;
  logic [TW-1:0] press_start_q, press_start_d;
  logic          out_valid_q, out_valid_d;

  bdpc_pkg::result_t result_q, result_d;

  logic          changed, deb_active, expire, edge_seen;
  logic          long_mid;
  logic [TW-1:0] deb_diff, press_diff, long_diff;
  logic          advance, step;

  assign advance     = !out_valid_q || out_ready_i;
  assign step        = item_valid_i && advance;
  assign item_take_o = advance;

  always_comb begin
    changed      = item_i.raw_level != filter_q;
    filter_d     = item_i.raw_level;
    deb_active   = changed || debouncing_q;
    deb_start_d  = changed ? item_i.now_ms : deb_start_q;
    deb_diff     = item_i.now_ms - deb_start_d;
    expire       = deb_active && (deb_diff >= {{(TW-CW){1'b0}}, cfg_i.debounce_ms});
    deb_d        = expire ? filter_d : deb_q;
    debouncing_d = deb_active && !expire;
    edge_seen    = deb_d != deb_q;

    result_d.press_event   = edge_seen && !deb_d;
    result_d.release_event = edge_seen && deb_d;
    press_diff = item_i.now_ms - press_start_q;
    result_d.short_press_event = result_d.release_event &&
      (press_diff <= {{(TW-CW){1'b0}}, cfg_i.short_max_ms});

    long_mid      = result_d.press_event || (long_pend_q && !result_d.release_event);
    press_start_d = result_d.press_event ? item_i.now_ms : press_start_q;
    long_diff     = item_i.now_ms - press_start_d;
    result_d.long_press_event = long_mid && !deb_d &&
      (long_diff >= {{(TW-CW){1'b0}}, cfg_i.long_min_ms});
    long_pend_d = long_mid && !result_d.long_press_event;

    result_d.stable_level = deb_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q      <= 1'b1;
      deb_q         <= 1'b1;
      debouncing_q  <= 1'b0;
      deb_start_q   <= '0;
      long_pend_q   <= 1'b0;
      press_start_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        filter_q      <= filter_d;
        deb_q         <= deb_d;
        debouncing_q  <= debouncing_d;
        deb_start_q   <= deb_start_d;
        long_pend_q   <= long_pend_d;
        press_start_q <= press_start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
